FILE: design/deq_pkg.sv
package deq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned KIND_W    = 3;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned STATUS_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_REAR  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_REAR   = 3'd3,
		KIND_LIST       = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic    push_front;
		logic    push_rear;
		logic    pop_front;
		logic    pop_rear;
		logic    list_clr;
		logic    rd_en;
		logic    emit_entry;
		logic    emit_status;
		status_t status;
	} deq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic out_free;
		logic list_last;
	} deq_stat_t;

endpackage

FILE: design/deq_req_if.sv
interface deq_req_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::KIND_W-1:0]          kind;
	logic signed [deq_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

FILE: design/deq_rsp_if.sv
interface deq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::STATUS_W-1:0]        status;
	logic signed [deq_pkg::VALUE_W-1:0]  entry;
	logic                                last;

	modport source (output valid, output status, output entry, output last, input ready);
	modport sink   (input valid, input status, input entry, input last, output ready);
endinterface

FILE: design/deq_ram.sv
module deq_ram #(
	parameter int unsigned WIDTH = deq_pkg::VALUE_W,
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/deq_ctrl.sv
module deq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [deq_pkg::KIND_W-1:0] req_kind,
	output logic                       req_ready,
	input  deq_pkg::deq_stat_t         stat,
	output deq_pkg::deq_cmd_t          cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LIST_RD,
		S_LIST_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   take;

	assign req_ready = (state_q == S_IDLE) && stat.out_free;
	assign take      = req_valid && req_ready;

	always_comb begin
		cmd     = '0;
		cmd.status = deq_pkg::ST_OK;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (deq_pkg::kind_t'(req_kind))
						deq_pkg::KIND_PUSH_FRONT,
						deq_pkg::KIND_PUSH_REAR: begin
							cmd.emit_status = 1'b1;
							if (stat.full) begin
								cmd.status = deq_pkg::ST_FULL;
							end else begin
								cmd.push_front = (req_kind == deq_pkg::KIND_PUSH_FRONT);
								cmd.push_rear  = (req_kind == deq_pkg::KIND_PUSH_REAR);
							end
						end
						deq_pkg::KIND_POP_FRONT,
						deq_pkg::KIND_POP_REAR: begin
							cmd.emit_status = 1'b1;
							if (stat.empty) begin
								cmd.status = deq_pkg::ST_EMPTY;
							end else begin
								cmd.pop_front = (req_kind == deq_pkg::KIND_POP_FRONT);
								cmd.pop_rear  = (req_kind == deq_pkg::KIND_POP_REAR);
							end
						end
						deq_pkg::KIND_LIST: begin
							if (stat.empty) begin
								cmd.emit_status = 1'b1;
								cmd.status      = deq_pkg::ST_EMPTY;
							end else begin
								cmd.list_clr = 1'b1;
								state_d      = S_LIST_RD;
							end
						end
						default: begin
							cmd.emit_status = 1'b1;
						end
					endcase
				end
			end
			S_LIST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LIST_OUT;
			end
			S_LIST_OUT: begin
				if (stat.out_free) begin
					cmd.emit_entry = 1'b1;
					state_d        = stat.list_last ? S_IDLE : S_LIST_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: design/deq_dp.sv
module deq_dp #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  deq_pkg::deq_cmd_t                   cmd,
	input  logic signed [deq_pkg::VALUE_W-1:0]  push_value,
	output deq_pkg::deq_stat_t                  stat,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [deq_pkg::STATUS_W-1:0]        rsp_status,
	output logic signed [deq_pkg::VALUE_W-1:0]  rsp_entry,
	output logic                                rsp_last
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = AW + 1;

	logic [AW-1:0] front_q;
	logic [CW-1:0] occ_q;
	logic [AW-1:0] list_ptr_q;
	logic [CW-1:0] list_cnt_q;

	logic                                rsp_valid_q;
	logic [deq_pkg::STATUS_W-1:0]        rsp_status_q;
	logic signed [deq_pkg::VALUE_W-1:0]  rsp_entry_q;
	logic                                rsp_last_q;

	logic [AW-1:0]                front_dec;
	logic [AW-1:0]                front_inc;
	logic [AW-1:0]                ptr_inc;
	logic [SW-1:0]                rear_sum;
	logic [AW-1:0]                rear_addr;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [deq_pkg::VALUE_W-1:0]  ram_rdata;
	logic                         list_last;

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign ptr_inc   = (list_ptr_q == AW'(DEPTH - 1)) ? '0 : list_ptr_q + 1'b1;
	assign rear_sum  = SW'(front_q) + SW'(occ_q);
	assign rear_addr = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);

	assign ram_we    = cmd.push_front || cmd.push_rear;
	assign ram_waddr = cmd.push_front ? front_dec : rear_addr;
	assign list_last = (list_cnt_q + CW'(1)) == occ_q;

	deq_ram #(
		.WIDTH (deq_pkg::VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (push_value),
		.re    (cmd.rd_en),
		.raddr (list_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			occ_q       <= '0;
			list_ptr_q  <= '0;
			list_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_dec;
			end else if (cmd.pop_front) begin
				front_q <= front_inc;
			end
			if (cmd.push_front || cmd.push_rear) begin
				occ_q <= occ_q + 1'b1;
			end else if (cmd.pop_front || cmd.pop_rear) begin
				occ_q <= occ_q - 1'b1;
			end
			if (cmd.list_clr) begin
				list_ptr_q <= front_q;
				list_cnt_q <= '0;
			end else if (cmd.emit_entry) begin
				list_ptr_q <= ptr_inc;
				list_cnt_q <= list_cnt_q + 1'b1;
			end
			if (cmd.emit_status || cmd.emit_entry) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_status) begin
			rsp_status_q <= cmd.status;
			rsp_entry_q  <= '0;
			rsp_last_q   <= 1'b1;
		end else if (cmd.emit_entry) begin
			rsp_status_q <= deq_pkg::ST_OK;
			rsp_entry_q  <= ram_rdata;
			rsp_last_q   <= list_last;
		end
	end

	assign stat.empty     = (occ_q == '0);
	assign stat.full      = (occ_q == CW'(DEPTH));
	assign stat.out_free  = !rsp_valid_q || rsp_ready;
	assign stat.list_last = list_last;

	assign rsp_valid  = rsp_valid_q;
	assign rsp_status = rsp_status_q;
	assign rsp_entry  = rsp_entry_q;
	assign rsp_last   = rsp_last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= AW'(DEPTH - 1))
		else $error("front index out of ring");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_rear) |-> !stat.full)
		else $error("push issued on full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_front || cmd.pop_rear || cmd.emit_entry) |-> !stat.empty)
		else $error("pop or list issued on empty queue");

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_status || cmd.emit_entry) |-> stat.out_free)
		else $error("result word overwritten");

endmodule

FILE: design/double_ended_queue.sv
// channel | dir | payload                 | accepted when
// req     | in  | kind[2:0], value[31:0]  | req.valid && req.ready
// rsp     | out | status, entry, last     | rsp.valid && rsp.ready
//
// Push, pop, unknown and empty-list requests are handled in S_IDLE; the result is registered.
// A list request starts in S_IDLE, then per entry: a store read, an emit when the slot frees.
// Reset clears the front index and occupancy; the store itself is not cleared.
// A stalled rsp holds its word; req is taken again once the result slot frees.
module double_ended_queue #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	deq_req_if.sink  req,
	deq_rsp_if.source rsp
);

	deq_pkg::deq_cmd_t  cmd;
	deq_pkg::deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (req.value),
		.stat       (stat),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_entry  (rsp.entry),
		.rsp_last   (rsp.last)
	);

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned DEPTH          = deq_pkg::DEPTH_DEF;
	localparam int unsigned RANDOM_WORDS   = 192;
	localparam int unsigned STALL_LIMIT    = 1000;
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam logic [deq_pkg::KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
	localparam logic [deq_pkg::KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;
	localparam int unsigned SEND_IDLE_PCT[3] = '{23, 46, 0};
	localparam int unsigned RECV_IDLE_PCT[3] = '{46, 23, 0};

	typedef struct packed {
		logic [deq_pkg::KIND_W-1:0]         kind;
		logic signed [deq_pkg::VALUE_W-1:0] value;
	} deq_request_t;

	typedef struct packed {
		deq_pkg::status_t                   status;
		logic signed [deq_pkg::VALUE_W-1:0] entry;
		logic                               last;
	} deq_result_t;

	logic clk;
	logic arst_n = 1'b0;

	deq_req_if req();
	deq_rsp_if rsp();

	double_ended_queue #(.DEPTH(DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	deq_request_t request_backlog[$];
	deq_result_t  awaited_results[$];

	logic signed [deq_pkg::VALUE_W-1:0] shadow_store[DEPTH];
	int unsigned shadow_front = 0;
	int unsigned shadow_count = 0;

	bit          req_fired = 1'b0;
	int unsigned words_taken = 0;
	int unsigned word_total = 1;
	int unsigned idle_phase = 0;
	int unsigned stall_cycles = 0;
	int unsigned fail_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void await_result(deq_pkg::status_t status,
			logic signed [deq_pkg::VALUE_W-1:0] entry, logic last);
		deq_result_t word;
		word.status = status;
		word.entry  = entry;
		word.last   = last;
		awaited_results.push_back(word);
	endfunction

	function automatic void deque_apply(logic [deq_pkg::KIND_W-1:0] kind,
			logic signed [deq_pkg::VALUE_W-1:0] value);
		int unsigned i;
		case (kind)
		deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
			if (shadow_count >= DEPTH) begin
				await_result(deq_pkg::ST_FULL, '0, 1'b1);
			end else begin
				if (kind == deq_pkg::KIND_PUSH_FRONT) begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_store[shadow_front] = value;
				end else begin
					shadow_store[(shadow_front + shadow_count) % DEPTH] = value;
				end
				shadow_count++;
				await_result(deq_pkg::ST_OK, '0, 1'b1);
			end
		end
		deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR: begin
			if (shadow_count == 0) begin
				await_result(deq_pkg::ST_EMPTY, '0, 1'b1);
			end else begin
				if (kind == deq_pkg::KIND_POP_FRONT)
					shadow_front = (shadow_front + 1) % DEPTH;
				shadow_count--;
				await_result(deq_pkg::ST_OK, '0, 1'b1);
			end
		end
		deq_pkg::KIND_LIST: begin
			if (shadow_count == 0) begin
				await_result(deq_pkg::ST_EMPTY, '0, 1'b1);
			end else begin
				for (i = 0; i < shadow_count; i++)
					await_result(deq_pkg::ST_OK,
						shadow_store[(shadow_front + i) % DEPTH],
						i + 1 == shadow_count);
			end
		end
		default: begin
			await_result(deq_pkg::ST_OK, '0, 1'b1);
		end
		endcase
	endfunction

	function automatic logic signed [deq_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(15))
		0: return 32'sh8000_0000;
		1: return 32'sh7fff_ffff;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic void add_request(logic [deq_pkg::KIND_W-1:0] kind,
			logic signed [deq_pkg::VALUE_W-1:0] value);
		deq_request_t item;
		item.kind  = kind;
		item.value = value;
		request_backlog.push_back(item);
	endfunction

	initial begin
		int unsigned                  i;
		int unsigned                  pick;
		int unsigned                  occ;
		bit                           filling;
		logic [deq_pkg::KIND_W-1:0]   kind;

		req.valid = 1'b0;
		req.kind  = '0;
		req.value = '0;
		rsp.ready = 1'b0;

		add_request(deq_pkg::KIND_LIST, pick_value());
		add_request(deq_pkg::KIND_POP_FRONT, pick_value());
		add_request(deq_pkg::KIND_POP_REAR, pick_value());
		add_request(KIND_RSVD_LAST, pick_value());
		add_request(deq_pkg::KIND_PUSH_FRONT, 32'sh8000_0000);
		add_request(deq_pkg::KIND_POP_REAR, pick_value());
		for (i = 0; i < DEPTH; i++) begin
			kind = i[0] ? deq_pkg::KIND_PUSH_REAR : deq_pkg::KIND_PUSH_FRONT;
			add_request(kind, i == 0 ? 32'sh7fff_ffff : i == 1 ? '1 : pick_value());
		end
		add_request(deq_pkg::KIND_PUSH_FRONT, pick_value());
		add_request(deq_pkg::KIND_PUSH_REAR, pick_value());
		add_request(deq_pkg::KIND_LIST, pick_value());
		add_request(deq_pkg::KIND_POP_FRONT, pick_value());
		add_request(deq_pkg::KIND_POP_REAR, pick_value());
		add_request(deq_pkg::KIND_LIST, pick_value());

		// walk the fill level up to full and back down to empty, over and over
		occ = DEPTH - 2;
		filling = 1'b0;
		for (i = 0; i < RANDOM_WORDS; i++) begin
			pick = $urandom_range(99);
			if (pick < 3) begin
				kind = deq_pkg::KIND_W'($urandom_range(KIND_RSVD_LAST, KIND_RSVD_FIRST));
			end else if (pick < 13) begin
				kind = deq_pkg::KIND_LIST;
			end else if ((pick < 88) == filling) begin
				kind = $urandom_range(1) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_REAR;
				if (occ < DEPTH)
					occ++;
			end else begin
				kind = $urandom_range(1) ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_REAR;
				if (occ > 0)
					occ--;
			end
			if (filling && occ == DEPTH && $urandom_range(3) == 0)
				filling = 1'b0;
			else if (!filling && occ == 0 && $urandom_range(3) == 0)
				filling = 1'b1;
			add_request(kind, pick_value());
		end
		word_total = request_backlog.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	always @(negedge clk) begin
		if (arst_n && (!req.valid || req_fired)) begin
			if (request_backlog.size() != 0 &&
					$urandom_range(99) >= SEND_IDLE_PCT[idle_phase]) begin
				req.valid <= 1'b1;
				req.kind  <= request_backlog[0].kind;
				req.value <= request_backlog[0].value;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rsp.ready <= arst_n && ($urandom_range(99) >= RECV_IDLE_PCT[idle_phase]);
	end

	always @(posedge clk) begin
		deq_result_t want;
		bit          rsp_fired;

		req_fired = arst_n && req.valid && req.ready;
		rsp_fired = arst_n && rsp.valid && rsp.ready;

		if (req_fired) begin
			deque_apply(req.kind, req.value);
			void'(request_backlog.pop_front());
			words_taken++;
			idle_phase = (words_taken * 3) / word_total;
			if (idle_phase > 2)
				idle_phase = 2;
		end

		if (rsp_fired) begin
			if (awaited_results.size() == 0) begin
				$error("result word with none expected: status %0d entry %0d last %0d",
					rsp.status, rsp.entry, rsp.last);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.entry !== want.entry) begin
					$error("entry: expected %0d, got %0d", want.entry, rsp.entry);
					fail_count++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp.last);
					fail_count++;
				end
			end
		end

		if (req_fired || rsp_fired || !arst_n)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule

FILE: filelist.f
design/deq_pkg.sv
design/deq_req_if.sv
design/deq_rsp_if.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue.sv
tb/sv/tb_top.sv
